// ===== sv/ansi_escape_stream_filter_macros.svh =====
// Assertion macros for the ANSI escape stream filter checker.
// Expects signals named clk and rst_n in the scope of each use.
`ifndef ANSI_ESCAPE_STREAM_FILTER_MACROS_SVH
`define ANSI_ESCAPE_STREAM_FILTER_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASCSF_HOLDS(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ascsf: property violated");

// Check that a condition is followed by another in the next cycle.
`define ASCSF_IMPLIES_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ascsf: sequence violated");

`endif

// ===== sv/ascsf_pkg.sv =====
// Shared types, character codes and helpers of the ANSI escape stream filter.
// No dependencies; imported by the top level and by the checker.
package ascsf_pkg;

  localparam int CSI_MAX = 32;
  localparam int LEN_W   = $clog2(CSI_MAX);
  localparam logic [LEN_W:0] CSI_MAX_W = (LEN_W + 1)'(CSI_MAX);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIP_ALL   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LIMIT = 2'd1;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_FRAME_LIM  = 3'd1;
  localparam logic [2:0] ST_UNKNOWN    = 3'd2;
  localparam logic [2:0] ST_UNTERM     = 3'd3;
  localparam logic [2:0] ST_CSI_LONG   = 3'd4;

  localparam logic [7:0] CH_BEL    = 8'h07;
  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_TWO    = 8'h32;
  localparam logic [7:0] CH_SIX    = 8'h36;
  localparam logic [7:0] CH_SEVEN  = 8'h37;
  localparam logic [7:0] CH_EIGHT  = 8'h38;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] FINAL_LO  = 8'h40;
  localparam logic [7:0] CH_J      = 8'h4A;
  localparam logic [7:0] CH_P      = 8'h50;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_C      = 8'h63;
  localparam logic [7:0] CH_H      = 8'h68;
  localparam logic [7:0] CH_L      = 8'h6C;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] FINAL_HI  = 8'h7E;

  // Parser phase, one-hot.
  typedef enum logic [7:0] {
    PH_TEXT    = 8'b0000_0001,
    PH_ESC     = 8'b0000_0010,
    PH_CSI     = 8'b0000_0100,
    PH_OSC     = 8'b0000_1000,
    PH_OSC_ESC = 8'b0001_0000,
    PH_DCS     = 8'b0010_0000,
    PH_DCS_ESC = 8'b0100_0000,
    PH_SCS     = 8'b1000_0000
  } phase_t;

  // Output sequencer, one-hot.
  typedef enum logic [2:0] {
    CTL_RUN    = 3'b001,
    CTL_PEND   = 3'b010,
    CTL_REPLAY = 3'b100
  } ctl_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       frame_mark;
    logic [2:0] status;
    logic       last;
  } res_t;

  function automatic res_t make_res(input logic [7:0] b, input logic bv, input logic fm,
                                    input logic [2:0] st, input logic lst);
    res_t r;
    r.out_byte   = b;
    r.byte_valid = bv;
    r.frame_mark = fm;
    r.status     = st;
    r.last       = lst;
    return r;
  endfunction

  // Expected parameter bytes of the synchronized-update mode "?2026".
  function automatic logic [7:0] sync_byte(input logic [LEN_W-1:0] idx);
    logic [7:0] b;
    case (idx)
      LEN_W'(3): b = CH_TWO;
      LEN_W'(4): b = CH_ZERO;
      LEN_W'(5): b = CH_TWO;
      LEN_W'(6): b = CH_SIX;
      default:   b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== sv/ascsf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Standalone; used for the CSI sequence buffer.
module ascsf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    // hold read data while no read is issued
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/ansi_escape_stream_filter.sv =====
// ANSI escape stream filter, top level.
// Depends on ascsf_pkg and ascsf_ram (CSI sequence buffer).
//
// Takes one terminal byte per word and passes plain text through at one byte per
// cycle unless out_tready stalls the output. ESC 7 / ESC 8 emit two words unless
// stripping. A CSI sequence is written byte by byte into a CSI_MAX-entry RAM and,
// at its final byte, either dropped or replayed: a replay emits the buffered bytes,
// read through the one RAM read port with registered read data, then the final
// byte, and no input word is taken meanwhile. Status results (frame limit, unknown
// escape, unterminated sequence, CSI overflow) stop the block; after that, input
// words are taken and discarded until reset. The buffer has no reset and needs no
// clearing pass: only entries written by the current sequence are read. cfg_ready
// is always high; write only while idle.
module ansi_escape_stream_filter
  import ascsf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] data_byte
  input  logic                  in_tuser,   // [0] end_of_stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [7:0]            out_tdata,  // [7:0] out_byte
  output logic [7:0]            out_tuser,  // [0] byte_valid, [1] frame_mark, [4:2] status
  output logic                  out_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  ctl_t             ctl_r, ctl_nxt;
  phase_t           phase_r, phase_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [15:0]      frames_r, frames_nxt;
  logic [2:0]       stopped_r, stopped_nxt;
  logic             strip_r;
  logic [15:0]      limit_r;
  logic             csi_qry_r, csi_qry_nxt;
  logic             csi_sync_r, csi_sync_nxt;
  logic [LEN_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic             rdv_r, rdv_nxt;
  logic [7:0]       fin_r, fin_nxt;
  logic             rfm_r, rfm_nxt;
  logic [7:0]       pend_r, pend_nxt;
  res_t             res_r, res_nxt;
  logic             ovalid_r, ovalid_nxt;

  logic             ram_we;
  logic [LEN_W-1:0] ram_waddr;
  logic [7:0]       ram_wdata;
  logic             ram_re;
  logic [7:0]       ram_rdata;

  logic             out_free;
  logic             acc;
  logic [7:0]       c;
  logic             is_final;
  logic [LEN_W:0]   len_p1;
  logic [15:0]      frames_inc;
  logic             limit_hit;
  logic             sync_hit;
  logic             keep_other;
  logic             emit;
  res_t             emit_res;
  logic             do_stop;
  logic [2:0]       stop_st;
  logic             stop_fm;
  logic             load;

  ascsf_ram #(
    .WIDTH(8),
    .DEPTH(CSI_MAX)
  ) u_csi_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(rd_ptr_r),
    .rdata(ram_rdata)
  );

  assign out_free  = !ovalid_r || out_tready;
  assign in_tready = (ctl_r == CTL_RUN) && out_free;
  assign acc       = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign c         = in_tdata;

  assign is_final   = (c >= FINAL_LO) && (c <= FINAL_HI);
  assign len_p1     = {1'b0, len_r} + {{LEN_W{1'b0}}, 1'b1};
  assign frames_inc = (frames_r == 16'hFFFF) ? frames_r : frames_r + 16'd1;
  assign limit_hit  = (limit_r != 16'd0) && (frames_inc >= limit_r);
  assign sync_hit   = (len_r == LEN_W'(7)) && csi_sync_r && ((c == CH_H) || (c == CH_L));
  assign keep_other = !strip_r && (c != CH_N) && (c != CH_C) && (c != CH_U) &&
                      (!csi_qry_r || sync_hit);

  always_comb begin
    ctl_nxt      = ctl_r;
    phase_nxt    = phase_r;
    len_nxt      = len_r;
    frames_nxt   = frames_r;
    stopped_nxt  = stopped_r;
    csi_qry_nxt  = csi_qry_r;
    csi_sync_nxt = csi_sync_r;
    rd_ptr_nxt   = rd_ptr_r;
    rdv_nxt      = rdv_r;
    fin_nxt      = fin_r;
    rfm_nxt      = rfm_r;
    pend_nxt     = pend_r;
    res_nxt      = res_r;
    ovalid_nxt   = ovalid_r && !out_tready;
    ram_we       = 1'b0;
    ram_waddr    = len_r;
    ram_wdata    = c;
    ram_re       = 1'b0;
    emit         = 1'b0;
    emit_res     = make_res(c, 1'b1, 1'b0, ST_OK, 1'b1);
    do_stop      = 1'b0;
    stop_st      = ST_OK;
    stop_fm      = 1'b0;
    load         = 1'b0;

    case (ctl_r)
      CTL_RUN: begin
        if (acc && (stopped_r == ST_OK)) begin
          if (in_tuser) begin
            if (phase_r != PH_TEXT) begin
              do_stop = 1'b1;
              stop_st = ST_UNTERM;
            end
          end else begin
            case (phase_r)
              PH_TEXT: begin
                if (c == CH_ESC) begin
                  // slot 0 of the buffer always holds the introducer
                  phase_nxt = PH_ESC;
                  ram_we    = 1'b1;
                  ram_waddr = '0;
                end else begin
                  emit = 1'b1;
                end
              end
              PH_ESC: begin
                phase_nxt = PH_TEXT;
                if ((c == CH_GT) || (c == CH_EQUAL)) begin
                  // drop
                end else if ((c == CH_SEVEN) || (c == CH_EIGHT)) begin
                  if (!strip_r) begin
                    emit     = 1'b1;
                    emit_res = make_res(CH_ESC, 1'b1, 1'b0, ST_OK, 1'b0);
                    pend_nxt = c;
                    ctl_nxt  = CTL_PEND;
                  end
                end else if (c == CH_LBRACK) begin
                  ram_we       = 1'b1;
                  ram_waddr    = LEN_W'(1);
                  len_nxt      = LEN_W'(2);
                  csi_qry_nxt  = 1'b0;
                  csi_sync_nxt = 1'b1;
                  phase_nxt    = PH_CSI;
                end else if (c == CH_RBRACK) begin
                  phase_nxt = PH_OSC;
                end else if (c == CH_P) begin
                  phase_nxt = PH_DCS;
                end else if ((c == CH_LPAREN) || (c == CH_RPAREN)) begin
                  phase_nxt = PH_SCS;
                end else begin
                  do_stop = 1'b1;
                  stop_st = ST_UNKNOWN;
                end
              end
              PH_CSI: begin
                if (is_final) begin
                  phase_nxt = PH_TEXT;
                  if (c == CH_J) begin
                    frames_nxt = frames_inc;
                    if (limit_hit) begin
                      do_stop = 1'b1;
                      stop_st = ST_FRAME_LIM;
                      stop_fm = 1'b1;
                    end else if (!strip_r) begin
                      ctl_nxt    = CTL_REPLAY;
                      rd_ptr_nxt = '0;
                      rdv_nxt    = 1'b0;
                      fin_nxt    = c;
                      rfm_nxt    = 1'b1;
                    end else begin
                      emit     = 1'b1;
                      emit_res = make_res(8'h00, 1'b0, 1'b1, ST_OK, 1'b1);
                      len_nxt  = '0;
                    end
                  end else if (keep_other) begin
                    ctl_nxt    = CTL_REPLAY;
                    rd_ptr_nxt = '0;
                    rdv_nxt    = 1'b0;
                    fin_nxt    = c;
                    rfm_nxt    = 1'b0;
                  end else begin
                    len_nxt = '0;
                  end
                end else if (len_p1 >= CSI_MAX_W) begin
                  do_stop = 1'b1;
                  stop_st = ST_CSI_LONG;
                end else begin
                  ram_we  = 1'b1;
                  len_nxt = len_p1[LEN_W-1:0];
                  // track the query mark and the "2026" mode digits as they land
                  if (len_r == LEN_W'(2)) begin
                    csi_qry_nxt = (c == CH_QMARK);
                  end
                  if ((len_r >= LEN_W'(3)) && (len_r <= LEN_W'(6))) begin
                    csi_sync_nxt = csi_sync_r && (c == sync_byte(len_r));
                  end
                end
              end
              PH_OSC, PH_OSC_ESC: begin
                if ((c == CH_BEL) || ((phase_r == PH_OSC_ESC) && (c == CH_BSLASH))) begin
                  phase_nxt = PH_TEXT;
                end else begin
                  phase_nxt = (c == CH_ESC) ? PH_OSC_ESC : PH_OSC;
                end
              end
              PH_DCS, PH_DCS_ESC: begin
                if ((phase_r == PH_DCS_ESC) && (c == CH_BSLASH)) begin
                  phase_nxt = PH_TEXT;
                end else begin
                  phase_nxt = (c == CH_ESC) ? PH_DCS_ESC : PH_DCS;
                end
              end
              PH_SCS: begin
                phase_nxt = PH_TEXT;
              end
              default: begin
                phase_nxt = PH_TEXT;
              end
            endcase
          end
        end
      end
      CTL_PEND: begin
        if (out_free) begin
          emit     = 1'b1;
          emit_res = make_res(pend_r, 1'b1, 1'b0, ST_OK, 1'b1);
          ctl_nxt  = CTL_RUN;
        end
      end
      CTL_REPLAY: begin
        // no writes happen here, so reads never overlap a pending write
        load = rdv_r && out_free;
        if (load) begin
          emit     = 1'b1;
          emit_res = make_res(ram_rdata, 1'b1, rfm_r, ST_OK, 1'b0);
        end
        if ((rd_ptr_r != len_r) && (!rdv_r || load)) begin
          ram_re     = 1'b1;
          rd_ptr_nxt = rd_ptr_r + LEN_W'(1);
          rdv_nxt    = 1'b1;
        end else if (load) begin
          rdv_nxt = 1'b0;
        end
        if ((rd_ptr_r == len_r) && !rdv_r && out_free) begin
          emit     = 1'b1;
          emit_res = make_res(fin_r, 1'b1, rfm_r, ST_OK, 1'b1);
          len_nxt  = '0;
          ctl_nxt  = CTL_RUN;
        end
      end
      default: begin
        ctl_nxt = CTL_RUN;
      end
    endcase

    if (do_stop) begin
      stopped_nxt = stop_st;
      phase_nxt   = PH_TEXT;
      len_nxt     = '0;
      emit        = 1'b1;
      emit_res    = make_res(8'h00, 1'b0, stop_fm, stop_st, 1'b1);
    end
    if (emit) begin
      ovalid_nxt = 1'b1;
      res_nxt    = emit_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r     <= CTL_RUN;
      phase_r   <= PH_TEXT;
      len_r     <= '0;
      frames_r  <= 16'd0;
      stopped_r <= ST_OK;
      ovalid_r  <= 1'b0;
      rdv_r     <= 1'b0;
      rd_ptr_r  <= '0;
      strip_r   <= 1'b0;
      limit_r   <= 16'd0;
    end else begin
      ctl_r     <= ctl_nxt;
      phase_r   <= phase_nxt;
      len_r     <= len_nxt;
      frames_r  <= frames_nxt;
      stopped_r <= stopped_nxt;
      ovalid_r  <= ovalid_nxt;
      rdv_r     <= rdv_nxt;
      rd_ptr_r  <= rd_ptr_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_STRIP_ALL) begin
          strip_r <= cfg_data[0];
        end else if (cfg_index == CFG_FRAME_LIMIT) begin
          limit_r <= cfg_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    csi_qry_r  <= csi_qry_nxt;
    csi_sync_r <= csi_sync_nxt;
    fin_r      <= fin_nxt;
    rfm_r      <= rfm_nxt;
    pend_r     <= pend_nxt;
    res_r      <= res_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = res_r.out_byte;
  assign out_tuser  = {3'b000, res_r.status, res_r.frame_mark, res_r.byte_valid};
  assign out_tlast  = res_r.last;

endmodule

// ===== sv/ascsf_checker.sv =====
// Port-level checker for the ANSI escape stream filter, bound to the top level.
// Depends on ascsf_pkg and ansi_escape_stream_filter_macros.svh.
`include "ansi_escape_stream_filter_macros.svh"

module ascsf_checker
  import ascsf_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [7:0] out_tuser,
  input logic       out_tlast
);

  // a stalled result word holds
  `ASCSF_IMPLIES_NEXT(a_out_hold, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))

  // a status word carries no byte and closes its input
  `ASCSF_HOLDS(a_status_shape, (out_tvalid && (out_tuser[4:2] != ST_OK)) |->
    (!out_tuser[0] && out_tlast && (out_tdata == 8'h00)))

  // a word without a byte is always the last of its input
  `ASCSF_HOLDS(a_novalid_last, (out_tvalid && !out_tuser[0]) |-> out_tlast)

  // after a status word is taken the block stays silent
  `ASCSF_IMPLIES_NEXT(a_stop_silent, out_tvalid && out_tready && (out_tuser[4:2] != ST_OK), !out_tvalid)

endmodule

bind ansi_escape_stream_filter ascsf_checker u_ascsf_checker (.*);

// ===== dv/tb_top.sv =====
// Self-checking testbench for ansi_escape_stream_filter: directed table, then random streams.
// Expected words come from an in-bench model of the escape parser.
// Depends on ascsf_pkg and the filter RTL.
module tb_top
  import ascsf_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_PCT         = 32;
  localparam int STALL_LIMIT      = 1000;
  localparam int SETTLE_CYCLES    = 40;
  localparam int RANDOM_PER_PHASE = 80;
  localparam logic [7:0] CH_SEMI  = 8'h3B;

  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_SILENT,
    ROW_TYPED
  } row_mode_t;

  typedef struct packed {
    logic [7:0] data;
    logic       eos;
    row_mode_t  mode;
    res_t       word;
  } stim_row_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata   = 8'h00;
  logic                  in_tuser   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [7:0]            out_tdata;
  logic [7:0]            out_tuser;
  logic                  out_tlast;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  // Parser model state
  phase_t      parse_state = PH_TEXT;
  logic [7:0]  seq_buf [CSI_MAX];
  int          seq_len     = 0;
  int          frame_count = 0;
  logic [2:0]  halt_code   = ST_OK;
  logic        strip_mode  = 1'b0;
  logic [15:0] frame_cap   = 16'h0000;
  res_t        held_word;
  bit          word_held   = 0;
  res_t        step_words[$];

  res_t        expected_words[$];
  logic [8:0]  queued_stream[$];  // {end_of_stream, byte}
  stim_row_t   dir_rows[$];
  bit          no_idle     = 0;
  int          error_count = 0;
  int          stall_cycles = 0;

  ansi_escape_stream_filter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------- model

  // Hold back the newest word so the final one of a step can get its last flag.
  function automatic void emit_word(input logic [7:0] b, input logic bv, input logic fm,
                                    input logic [2:0] st);
    if (word_held) step_words.push_back(held_word);
    held_word.out_byte   = b;
    held_word.byte_valid = bv;
    held_word.frame_mark = fm;
    held_word.status     = st;
    held_word.last       = 1'b0;
    word_held = 1;
  endfunction

  function automatic void halt_filter(input logic [2:0] st, input logic fm);
    halt_code   = st;
    parse_state = PH_TEXT;
    seq_len     = 0;
    emit_word(8'h00, 1'b0, fm, st);
  endfunction

  function automatic void replay_sequence(input logic [7:0] fin, input logic fm);
    for (int i = 0; i < seq_len; i++) emit_word(seq_buf[i], 1'b1, fm, ST_OK);
    emit_word(fin, 1'b1, fm, ST_OK);
  endfunction

  function automatic void close_sequence(input logic [7:0] c);
    logic [7:0] lead;
    bit         sync_mode;
    lead = (seq_len > 2) ? seq_buf[2] : c;
    if (c == CH_J) begin
      if (frame_count != 65535) frame_count++;
      if (frame_cap != 0 && frame_count >= frame_cap) begin
        halt_filter(ST_FRAME_LIM, 1'b1);
        return;
      end
      if (!strip_mode) replay_sequence(c, 1'b1);
      else emit_word(8'h00, 1'b0, 1'b1, ST_OK);
    end else begin
      sync_mode = seq_len == 7 && (c == CH_H || c == CH_L) && seq_buf[3] == CH_TWO &&
                  seq_buf[4] == CH_ZERO && seq_buf[5] == CH_TWO && seq_buf[6] == CH_SIX;
      if (!strip_mode && c != CH_N && c != CH_C && c != CH_U &&
          (lead != CH_QMARK || sync_mode))
        replay_sequence(c, 1'b0);
    end
    seq_len     = 0;
    parse_state = PH_TEXT;
  endfunction

  // Advance the model by one input word; the words it causes land in step_words.
  function automatic void filter_byte(input logic [7:0] c, input logic eos);
    step_words.delete();
    word_held = 0;
    if (halt_code == ST_OK) begin
      if (eos) begin
        if (parse_state != PH_TEXT) halt_filter(ST_UNTERM, 1'b0);
      end else begin
        case (parse_state)
          PH_TEXT: begin
            if (c == CH_ESC) parse_state = PH_ESC;
            else emit_word(c, 1'b1, 1'b0, ST_OK);
          end
          PH_ESC: begin
            parse_state = PH_TEXT;
            if (c == CH_GT || c == CH_EQUAL) begin
            end else if (c == CH_SEVEN || c == CH_EIGHT) begin
              if (!strip_mode) begin
                emit_word(CH_ESC, 1'b1, 1'b0, ST_OK);
                emit_word(c, 1'b1, 1'b0, ST_OK);
              end
            end else if (c == CH_LBRACK) begin
              seq_buf[0]  = CH_ESC;
              seq_buf[1]  = CH_LBRACK;
              seq_len     = 2;
              parse_state = PH_CSI;
            end else if (c == CH_RBRACK) begin
              parse_state = PH_OSC;
            end else if (c == CH_P) begin
              parse_state = PH_DCS;
            end else if (c == CH_LPAREN || c == CH_RPAREN) begin
              parse_state = PH_SCS;
            end else begin
              halt_filter(ST_UNKNOWN, 1'b0);
            end
          end
          PH_CSI: begin
            if (c >= FINAL_LO && c <= FINAL_HI) begin
              close_sequence(c);
            end else if (seq_len + 1 >= CSI_MAX) begin
              halt_filter(ST_CSI_LONG, 1'b0);
            end else begin
              seq_buf[seq_len] = c;
              seq_len++;
            end
          end
          PH_OSC, PH_OSC_ESC: begin
            if (c == CH_BEL || (parse_state == PH_OSC_ESC && c == CH_BSLASH))
              parse_state = PH_TEXT;
            else
              parse_state = (c == CH_ESC) ? PH_OSC_ESC : PH_OSC;
          end
          PH_DCS, PH_DCS_ESC: begin
            if (parse_state == PH_DCS_ESC && c == CH_BSLASH) parse_state = PH_TEXT;
            else parse_state = (c == CH_ESC) ? PH_DCS_ESC : PH_DCS;
          end
          default: parse_state = PH_TEXT;
        endcase
      end
    end
    if (word_held) begin
      held_word.last = 1'b1;
      step_words.push_back(held_word);
      word_held = 0;
    end
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic res_t text_word(input logic [7:0] b);
    res_t w;
    w.out_byte   = b;
    w.byte_valid = 1'b1;
    w.frame_mark = 1'b0;
    w.status     = ST_OK;
    w.last       = 1'b1;
    return w;
  endfunction

  function automatic void add_row(input logic [7:0] b, input logic eos, input row_mode_t mode,
                                  input res_t word);
    stim_row_t row;
    row.data = b;
    row.eos  = eos;
    row.mode = mode;
    row.word = word;
    dir_rows.push_back(row);
  endfunction

  function automatic void push_byte(input logic [7:0] b);
    queued_stream.push_back({1'b0, b});
  endfunction

  function automatic logic [7:0] param_byte();
    return ($urandom_range(0, 3) == 0) ? CH_SEMI : CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] final_byte();
    case ($urandom_range(0, 9))
      0:       return CH_J;
      1:       return CH_N;
      2:       return CH_C;
      3:       return CH_U;
      4:       return CH_H;
      5:       return CH_L;
      default: return 8'($urandom_range(FINAL_LO, FINAL_HI));
    endcase
  endfunction

  // Queue one well-formed escape sequence with random content.
  function automatic void queue_sequence();
    int n;
    push_byte(CH_ESC);
    case ($urandom_range(0, 9))
      0, 1: begin
        push_byte(CH_LBRACK);
        n = $urandom_range(0, 4);
        repeat (n) push_byte(param_byte());
        push_byte(final_byte());
      end
      2: begin
        push_byte(CH_LBRACK);
        push_byte(CH_QMARK);
        push_byte(CH_TWO);
        push_byte(CH_ZERO);
        push_byte(CH_TWO);
        push_byte(CH_SIX);
        push_byte($urandom_range(0, 1) ? CH_H : CH_L);
      end
      3: begin
        push_byte(CH_LBRACK);
        push_byte(CH_QMARK);
        n = $urandom_range(0, 4);
        repeat (n) push_byte(param_byte());
        push_byte(final_byte());
      end
      4: begin
        case ($urandom_range(0, 3))
          0:       push_byte(CH_SEVEN);
          1:       push_byte(CH_EIGHT);
          2:       push_byte(CH_GT);
          default: push_byte(CH_EQUAL);
        endcase
      end
      5: begin
        push_byte($urandom_range(0, 1) ? CH_LPAREN : CH_RPAREN);
        push_byte(8'($urandom_range(0, 255)));
      end
      6: begin
        push_byte(CH_RBRACK);
        n = $urandom_range(0, 6);
        repeat (n) push_byte(8'($urandom_range(8'h20, 8'hFF)));
        if ($urandom_range(0, 1)) begin
          push_byte(CH_BEL);
        end else begin
          push_byte(CH_ESC);
          push_byte(CH_BSLASH);
        end
      end
      7: begin
        push_byte(CH_P);
        n = $urandom_range(0, 6);
        repeat (n) push_byte(8'($urandom_range(8'h20, 8'hFF)));
        push_byte(CH_ESC);
        push_byte(CH_BSLASH);
      end
      8: begin
        push_byte(CH_LBRACK);
        if ($urandom_range(0, 1)) push_byte(CH_TWO);
        push_byte(CH_J);
      end
      default: begin
        // long sequence, up to a full buffer
        push_byte(CH_LBRACK);
        n = $urandom_range(20, CSI_MAX - 3);
        repeat (n) push_byte(8'($urandom_range(8'h20, 8'h3F)));
        push_byte(final_byte());
      end
    endcase
  endfunction

  task automatic send_word(input logic [7:0] b, input logic eos, input row_mode_t mode,
                           input res_t word);
    int gap;
    gap = 0;
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) gap++;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= eos;
    do @(posedge clk); while (!in_tready);
    filter_byte(b, eos);
    case (mode)
      ROW_PREDICT: foreach (step_words[i]) expected_words.push_back(step_words[i]);
      ROW_TYPED:   expected_words.push_back(word);
      default: ;
    endcase
  endtask

  // Drive random words until count is spent, no queued bytes are left and the parser is back in text.
  task automatic run_random(input int count);
    logic [7:0] b;
    logic       eos;
    int         r;
    while (count > 0 || parse_state != PH_TEXT || queued_stream.size() != 0) begin
      eos = 1'b0;
      b   = 8'($urandom_range(0, 255));
      r   = $urandom_range(0, 99);
      if (queued_stream.size() != 0) begin
        {eos, b} = queued_stream.pop_front();
      end else begin
        case (parse_state)
          PH_TEXT: begin
            if (r < 26) begin
              queue_sequence();
              {eos, b} = queued_stream.pop_front();
            end else if (r < 31) begin
              b = CH_ESC;
            end else if (r < 35) begin
              eos = 1'b1;
            end else if (b == CH_ESC) begin
              b = ~b;
            end
          end
          PH_ESC: begin
            case (r % 9)
              0:       b = CH_GT;
              1:       b = CH_EQUAL;
              2:       b = CH_SEVEN;
              3:       b = CH_EIGHT;
              4:       b = CH_LBRACK;
              5:       b = CH_RBRACK;
              6:       b = CH_P;
              7:       b = CH_LPAREN;
              default: b = CH_RPAREN;
            endcase
          end
          PH_CSI: begin
            // close before the buffer overflows
            if (seq_len + 1 >= CSI_MAX || r < 20) b = 8'($urandom_range(FINAL_LO, FINAL_HI));
            else if (b >= FINAL_LO && b <= FINAL_HI) b = 8'($urandom_range(8'h20, 8'h3F));
          end
          PH_OSC, PH_OSC_ESC: begin
            if (r < 10) b = CH_BEL;
            else if (r < 20) b = CH_ESC;
            else if (parse_state == PH_OSC_ESC && r < 60) b = CH_BSLASH;
          end
          PH_DCS, PH_DCS_ESC: begin
            if (r < 15) b = CH_ESC;
            else if (parse_state == PH_DCS_ESC && r < 60) b = CH_BSLASH;
          end
          default: ;
        endcase
      end
      send_word(b, eos, ROW_PREDICT, '0);
      count--;
    end
    in_tvalid <= 1'b0;
  endtask

  task automatic program_filter(input logic strip, input logic [15:0] cap);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_STRIP_ALL;
    cfg_data  <= {15'($urandom), strip};
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_FRAME_LIMIT;
    cfg_data  <= cap;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    strip_mode = strip;
    frame_cap  = cap;
  endtask

  task automatic wait_idle();
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- checking

  always @(posedge clk) begin
    out_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk) begin : check_words
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_words.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected word: byte %h user %h last %b", out_tdata, out_tuser,
                   out_tlast);
      end else begin
        want = expected_words.pop_front();
        if (out_tdata !== want.out_byte || out_tuser[0] !== want.byte_valid ||
            out_tuser[1] !== want.frame_mark || out_tuser[4:2] !== want.status ||
            out_tlast !== want.last) begin
          error_count++;
          if (error_count <= 10)
            $display("mismatch: got byte %h valid %b mark %b status %0d last %b, %s",
                     out_tdata, out_tuser[0], out_tuser[1], out_tuser[4:2], out_tlast,
                     $sformatf("want %h %b %b %0d %b", want.out_byte, want.byte_valid,
                               want.frame_mark, want.status, want.last));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    int         stop_kind;
    logic [7:0] b;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    program_filter(1'b0, 16'h0000);

    add_row(8'h00, 1'b0, ROW_TYPED, text_word(8'h00));
    add_row(8'hFF, 1'b0, ROW_TYPED, text_word(8'hFF));
    add_row(8'h00, 1'b1, ROW_SILENT, '0);       // end of stream in text: nothing
    add_row(CH_ESC, 1'b0, ROW_PREDICT, '0);
    add_row(CH_EQUAL, 1'b0, ROW_PREDICT, '0);
    add_row(CH_ESC, 1'b0, ROW_PREDICT, '0);
    add_row(CH_EIGHT, 1'b0, ROW_PREDICT, '0);
    add_row(CH_ESC, 1'b0, ROW_PREDICT, '0);
    add_row(CH_RPAREN, 1'b0, ROW_PREDICT, '0);
    add_row(CH_J, 1'b0, ROW_PREDICT, '0);       // designator byte, dropped
    add_row(CH_ESC, 1'b0, ROW_PREDICT, '0);
    add_row(CH_RBRACK, 1'b0, ROW_PREDICT, '0);
    add_row(CH_BEL, 1'b0, ROW_PREDICT, '0);
    add_row(CH_ESC, 1'b0, ROW_PREDICT, '0);
    add_row(CH_P, 1'b0, ROW_PREDICT, '0);
    add_row(CH_ESC, 1'b0, ROW_PREDICT, '0);
    add_row(CH_BSLASH, 1'b0, ROW_PREDICT, '0);
    add_row(CH_ESC, 1'b0, ROW_PREDICT, '0);
    add_row(CH_LBRACK, 1'b0, ROW_PREDICT, '0);
    add_row(CH_J, 1'b0, ROW_PREDICT, '0);       // bare clear screen, final is first byte
    add_row(CH_ESC, 1'b0, ROW_PREDICT, '0);
    add_row(CH_LBRACK, 1'b0, ROW_PREDICT, '0);
    add_row(CH_QMARK, 1'b0, ROW_PREDICT, '0);
    add_row(CH_TWO, 1'b0, ROW_PREDICT, '0);
    add_row(CH_ZERO, 1'b0, ROW_PREDICT, '0);
    add_row(CH_TWO, 1'b0, ROW_PREDICT, '0);
    add_row(CH_SIX, 1'b0, ROW_PREDICT, '0);
    add_row(CH_L, 1'b0, ROW_PREDICT, '0);       // synchronized update end, replayed

    foreach (dir_rows[i])
      send_word(dir_rows[i].data, dir_rows[i].eos, dir_rows[i].mode, dir_rows[i].word);
    in_tvalid <= 1'b0;
    wait_idle();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       program_filter(1'b1, 16'hFFFF);
        1:       program_filter(1'b0, 16'(frame_count + 300 + $urandom_range(0, 4000)));
        2:       program_filter(1'b1, 16'h0000);
        default: program_filter(1'b0, 16'h0000);
      endcase
      no_idle = (p == 1);
      run_random(RANDOM_PER_PHASE);
      wait_idle();
    end

    // End with one stopping condition; later words must be swallowed.
    stop_kind = $urandom_range(0, 3);
    case (stop_kind)
      0: begin
        program_filter(strip_mode, (frame_count >= 65535) ? 16'hFFFF : 16'(frame_count + 1));
        push_byte(CH_ESC);
        push_byte(CH_LBRACK);
        push_byte(CH_TWO);
        push_byte(CH_J);
      end
      1: begin
        b = 8'($urandom_range(0, 255));
        case (b)
          CH_GT, CH_EQUAL, CH_SEVEN, CH_EIGHT, CH_LBRACK, CH_RBRACK, CH_P, CH_LPAREN,
          CH_RPAREN: b = CH_ESC;
          default: ;
        endcase
        push_byte(CH_ESC);
        push_byte(b);
      end
      2: begin
        push_byte(CH_ESC);
        case ($urandom_range(0, 4))
          0: ;
          1: begin
            push_byte(CH_LBRACK);
            push_byte(param_byte());
          end
          2: begin
            push_byte(CH_RBRACK);
            push_byte(8'($urandom_range(8'h20, 8'hFF)));
          end
          3: push_byte(CH_P);
          default: push_byte(CH_LPAREN);
        endcase
        queued_stream.push_back({1'b1, 8'($urandom)});
      end
      default: begin
        push_byte(CH_ESC);
        push_byte(CH_LBRACK);
        repeat (CSI_MAX - 2) push_byte(8'($urandom_range(8'h20, 8'h3F)));
      end
    endcase
    run_random(queued_stream.size() + 8);
    wait_idle();

    if (error_count == 0 && expected_words.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
